### src/cgnt_pkg.sv
// Package for the Canny gradient, suppression and threshold block.
// Holds the fixed field widths, register indexes, direction and class codes
// and the structs that travel down the pipeline. Depends on nothing.
package cgnt_pkg;

    // Fixed field widths
    localparam int PIXEL_IN_BITS = 8;
    localparam int SIZE_BITS     = 12;
    localparam int ROW_BITS      = 12;
    localparam int MAG_BITS      = 17;
    localparam int CLASS_BITS    = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam int OUT_DATA_BITS = ((MAG_BITS + 7) / 8) * 8;

    // Limits and reset values
    localparam logic [MAG_BITS-1:0]  MAG_MAX      = '1;
    localparam logic [SIZE_BITS-1:0] MAX_HEIGHT   = 12'd2048;
    localparam logic [SIZE_BITS-1:0] MIN_SIZE     = 12'd3;
    localparam int                   WIDTH_RESET  = 640;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 12'd480;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_HIGH   = 2'd2,
        CFG_LOW    = 2'd3
    } cfg_idx_t;

    // Gradient direction bins
    typedef enum logic [1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } dir_t;

    // Edge classes
    typedef enum logic [CLASS_BITS-1:0] {
        CLS_NONE   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } edge_class_t;

    // One column of the magnitude line buffer: middle and bottom rows
    typedef struct packed {
        logic [MAG_BITS-1:0] mid;
        dir_t                dir;
        logic [MAG_BITS-1:0] bot;
    } mag_col_t;

    // One column of the 3x3 magnitude window; top is the newest row
    typedef struct packed {
        logic [MAG_BITS-1:0] top;
        logic [MAG_BITS-1:0] mid;
        dir_t                dir;
        logic [MAG_BITS-1:0] bot;
    } win_col_t;

    // Frame-border masks for the gradient stage
    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic up_ok;
    } grad_flags_t;

    // Control for the suppression stage
    typedef struct packed {
        logic emit;
        logic edge_c;
        logic edge_r;
        logic last;
    } supp_flags_t;

    // One result beat
    typedef struct packed {
        logic                last;
        edge_class_t         cls;
        logic [MAG_BITS-1:0] mag;
    } result_t;

endpackage

### src/canny_gradient_nms_threshold.sv
// Canny gradient, non-maximum suppression and double threshold, streaming.
// Throughput: one item per clock while the skid slot is empty; each item costs one read and
// one write on each line buffer. A result is registered through the stage registers into the output
// register; the result of pixel q of a frame is caused by item q + 2W + 1, so 2W + 1 drain beats end a frame.
// Reset clears counters, pipeline and output valids and sets 640x480, thresholds zero;
// line buffers are not cleared (border masks hide entries not yet written this frame).
module canny_gradient_nms_threshold #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cgnt_pkg::PIXEL_IN_BITS-1:0]  s_axis_tdata,  // [7:0] pixel
    input  logic [0:0]                          s_axis_tuser,  // [0] action (1 = drain)
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cgnt_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // [16:0] kept_mag_sq, rest zero
    output logic [cgnt_pkg::CLASS_BITS-1:0]     m_axis_tuser,  // [1:0] edge_class
    output logic                                m_axis_tlast,  // frame_last
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cgnt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cgnt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import cgnt_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int PB   = PIXEL_BITS;
    localparam int PIN  = (PIXEL_BITS < PIXEL_IN_BITS) ? PIXEL_BITS : PIXEL_IN_BITS;
    localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [WCW-1:0]       w_eff_reg;
    logic [SIZE_BITS-1:0] h_eff_reg;
    logic [MAG_BITS-1:0]  high_thr_reg;
    logic [MAG_BITS-1:0]  low_thr_reg;
    logic [WCW-1:0]       w_cfg;
    logic [SIZE_BITS-1:0] h_cfg;
    logic                 cfg_wr;
    logic                 size_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign size_wr   = cfg_wr && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

    // Clamp the frame size as it is written
    always_comb
    begin
        if (cfg_data[SIZE_BITS-1:0] < MIN_SIZE)
        begin
            w_cfg = WCW'(MIN_SIZE);
        end
        else if (int'(cfg_data[SIZE_BITS-1:0]) > MAX_WIDTH)
        begin
            w_cfg = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_cfg = WCW'(cfg_data[SIZE_BITS-1:0]);
        end

        if (cfg_data[SIZE_BITS-1:0] < MIN_SIZE)
        begin
            h_cfg = MIN_SIZE;
        end
        else if (cfg_data[SIZE_BITS-1:0] > MAX_HEIGHT)
        begin
            h_cfg = MAX_HEIGHT;
        end
        else
        begin
            h_cfg = cfg_data[SIZE_BITS-1:0];
        end
    end

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg    <= WCW'(W_RESET);
            h_eff_reg    <= HEIGHT_RESET;
            high_thr_reg <= '0;
            low_thr_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  w_eff_reg    <= w_cfg;
                CFG_HEIGHT: h_eff_reg    <= h_cfg;
                CFG_HIGH:   high_thr_reg <= cfg_data[MAG_BITS-1:0];
                CFG_LOW:    low_thr_reg  <= cfg_data[MAG_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: position counters and border flags
    // ------------------------------------------------------------------
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                skid_valid_reg;
    logic                adv;
    logic                noop;
    logic                act;
    logic                col_zero;
    logic                col_last;
    logic [ROW_BITS:0]   row_x, h_p1, h_p2;
    logic [PB-1:0]       pix_in;
    logic [PB-1:0]       pcur;
    grad_flags_t         in_grad;
    supp_flags_t         in_supp;
    logic [CW-1:0]       look_addr;

    // The whole pipeline moves while the skid slot is free
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign noop          = s_axis_tuser[0] && (row_reg == '0) && (col_reg == '0);
    assign act           = s_axis_tvalid && s_axis_tready && !noop;
    assign pix_in        = PB'(s_axis_tdata[PIN-1:0]);

    always_comb
    begin
        col_zero = (col_reg == '0);
        col_last = (WCW'(col_reg) + WCW'(1)) == w_eff_reg;
        row_x    = {1'b0, row_reg};
        h_p1     = {1'b0, h_eff_reg} + (ROW_BITS+1)'(1);
        h_p2     = {1'b0, h_eff_reg} + (ROW_BITS+1)'(2);

        // Pixel stored for this beat: drains and rows past the frame read as zero
        pcur = (!s_axis_tuser[0] && (row_reg < h_eff_reg)) ? pix_in : '0;

        in_grad.left_ok  = !col_zero;
        in_grad.right_ok = !col_last;
        in_grad.up_ok    = (row_reg >= ROW_BITS'(2));

        // The pixel judged here is two rows up, one column left (or the row end)
        if (col_zero)
        begin
            in_supp.emit   = (row_x >= (ROW_BITS+1)'(3)) && (row_x <= h_p2);
            in_supp.edge_r = (row_x == (ROW_BITS+1)'(3)) || (row_x == h_p2);
        end
        else
        begin
            in_supp.emit   = (row_x >= (ROW_BITS+1)'(2)) && (row_x <= h_p1);
            in_supp.edge_r = (row_x == (ROW_BITS+1)'(2)) || (row_x == h_p1);
        end
        in_supp.edge_c = (col_reg <= CW'(1));
        in_supp.last   = col_zero && (row_x == h_p2);

        look_addr = col_last ? '0 : col_reg + CW'(1);
    end

    // Advance the raster position; a size write starts a new frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (size_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (act)
        begin
            if (in_supp.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel line buffer: each column holds {row above, two rows above}
    // ------------------------------------------------------------------
    logic [2*PB-1:0] pix_q;
    logic [2*PB-1:0] pix_wdata;
    logic [2*PB-1:0] pw_c_reg;
    logic [2*PB-1:0] pw_l_reg;

    assign pix_wdata = {pcur, pix_q[2*PB-1:PB]};

    // Read one column ahead so the right neighbour is ready with the beat
    cgnt_ram #(
        .WIDTH (2*PB),
        .DEPTH (MAX_WIDTH)
    ) u_pix_ram (
        .clk     (clk),
        .wr_en   (act),
        .wr_addr (col_reg),
        .wr_data (pix_wdata),
        .rd_en   (act),
        .rd_addr (look_addr),
        .rd_data (pix_q)
    );

    // Stage 1 registers
    logic          s1_valid_reg;
    logic [PB-1:0] s1_pcur_reg;
    grad_flags_t   s1_grad_reg;
    supp_flags_t   s1_supp_reg;
    logic [CW-1:0] s1_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= act;
        end
    end

    // Hold the beat and shift the pixel column window
    always_ff @(posedge clk)
    begin
        if (act)
        begin
            s1_pcur_reg <= pcur;
            s1_grad_reg <= in_grad;
            s1_supp_reg <= in_supp;
            s1_col_reg  <= col_reg;
            pw_c_reg    <= pix_q;
            pw_l_reg    <= pw_c_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: central differences, squared magnitude, direction bin
    // ------------------------------------------------------------------
    logic [PB-1:0]          p_r, p_l, p_u;
    logic signed [PB:0]     gx, gy;
    logic [PB-1:0]          ax, ay;
    logic [2*PB-1:0]        sq_x, sq_y;
    logic [2*PB:0]          m_full;
    logic [PB:0]            a_sum;
    logic [2*PB+1:0]        s_sq, two_x, two_y;
    logic                   gx_pos, gy_pos;
    logic [MAG_BITS-1:0]    g_mag;
    dir_t                   g_dir;

    always_comb
    begin
        p_r = s1_grad_reg.right_ok ? pix_q[2*PB-1:PB]    : '0;
        p_l = s1_grad_reg.left_ok  ? pw_l_reg[2*PB-1:PB] : '0;
        p_u = s1_grad_reg.up_ok    ? pw_c_reg[PB-1:0]    : '0;

        gx = $signed({1'b0, p_r}) - $signed({1'b0, p_l});
        gy = $signed({1'b0, s1_pcur_reg}) - $signed({1'b0, p_u});
        ax = gx[PB] ? PB'(-gx) : PB'(gx);
        ay = gy[PB] ? PB'(-gy) : PB'(gy);

        sq_x   = (2*PB)'(ax) * (2*PB)'(ax);
        sq_y   = (2*PB)'(ay) * (2*PB)'(ay);
        m_full = (2*PB+1)'(sq_x) + (2*PB+1)'(sq_y);
        g_mag  = (|(m_full >> MAG_BITS)) ? MAG_MAX : MAG_BITS'(m_full);

        // Bin limits at tan(22.5) and tan(67.5), compared without roots
        a_sum = (PB+1)'(ax) + (PB+1)'(ay);
        s_sq  = (2*PB+2)'(a_sum) * (2*PB+2)'(a_sum);
        two_x = {1'b0, sq_x, 1'b0};
        two_y = {1'b0, sq_y, 1'b0};
        gx_pos = !gx[PB] && (gx != '0);
        gy_pos = !gy[PB] && (gy != '0);

        if (s_sq < two_x)
        begin
            g_dir = DIR_0;
        end
        else if (s_sq < two_y)
        begin
            g_dir = DIR_90;
        end
        else if (gx_pos == gy_pos)
        begin
            g_dir = DIR_45;
        end
        else
        begin
            g_dir = DIR_135;
        end
    end

    // Stage 2 registers
    logic                s2_valid_reg;
    logic [MAG_BITS-1:0] s2_mag_reg;
    dir_t                s2_dir_reg;
    supp_flags_t         s2_supp_reg;
    logic [CW-1:0]       s2_col_reg;
    logic                s1_adv;
    logic                s2_adv;

    assign s1_adv = adv && s1_valid_reg;
    assign s2_adv = adv && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_mag_reg  <= g_mag;
            s2_dir_reg  <= g_dir;
            s2_supp_reg <= s1_supp_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Magnitude line buffer: each column holds {row above with its bin, two rows above}
    // ------------------------------------------------------------------
    mag_col_t mq;
    mag_col_t mag_wdata;
    win_col_t t0;
    win_col_t t1_reg;
    win_col_t t2_reg;

    assign mag_wdata = '{mid: s2_mag_reg, dir: s2_dir_reg, bot: mq.mid};
    assign t0        = '{top: s2_mag_reg, mid: mq.mid, dir: mq.dir, bot: mq.bot};

    cgnt_ram #(
        .WIDTH ($bits(mag_col_t)),
        .DEPTH (MAX_WIDTH)
    ) u_mag_ram (
        .clk     (clk),
        .wr_en   (s2_adv),
        .wr_addr (s2_col_reg),
        .wr_data (mag_wdata),
        .rd_en   (s1_adv),
        .rd_addr (s1_col_reg),
        .rd_data (mq)
    );

    // Shift the magnitude window by one column per beat
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            t1_reg <= t0;
            t2_reg <= t1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: suppression along the bin and double threshold
    // ------------------------------------------------------------------
    logic [MAG_BITS-1:0] nb_a, nb_b;
    logic                blocked;
    logic [MAG_BITS-1:0] kept;
    result_t             res;

    always_comb
    begin
        case (t1_reg.dir)
            DIR_0:
            begin
                nb_a    = t2_reg.mid;
                nb_b    = t0.mid;
                blocked = s2_supp_reg.edge_c;
            end
            DIR_45:
            begin
                nb_a    = t2_reg.bot;
                nb_b    = t0.top;
                blocked = s2_supp_reg.edge_c || s2_supp_reg.edge_r;
            end
            DIR_90:
            begin
                nb_a    = t1_reg.bot;
                nb_b    = t1_reg.top;
                blocked = s2_supp_reg.edge_r;
            end
            default:
            begin
                nb_a    = t0.bot;
                nb_b    = t2_reg.top;
                blocked = s2_supp_reg.edge_c || s2_supp_reg.edge_r;
            end
        endcase

        // Keep only a local maximum; ties keep the pixel
        if ((t1_reg.mid != '0) && !blocked && (t1_reg.mid >= nb_a) && (t1_reg.mid >= nb_b))
        begin
            kept = t1_reg.mid;
        end
        else
        begin
            kept = '0;
        end

        res.mag  = kept;
        res.last = s2_supp_reg.last;
        if (kept > high_thr_reg)
        begin
            res.cls = CLS_STRONG;
        end
        else if (kept > low_thr_reg)
        begin
            res.cls = CLS_WEAK;
        end
        else
        begin
            res.cls = CLS_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid slot
    // ------------------------------------------------------------------
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_next;
    result_t out_res_reg, out_res_next;
    result_t skid_res_reg, skid_res_next;
    logic    push;
    logic    take;

    assign push = s2_adv && s2_supp_reg.emit;
    assign take = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            // Refill the output from the skid slot once the beat goes
            if (take)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    // Drive the result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_res_reg.mag);
    assign m_axis_tuser  = out_res_reg.cls;
    assign m_axis_tlast  = out_res_reg.last;

endmodule

### src/cgnt_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the pixel and magnitude line buffers. No dependencies.
module cgnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### tb/tb_canny_gradient_nms_threshold.sv
// Testbench for canny_gradient_nms_threshold: gradient, suppression and double threshold.
// Drives pixel frames over the input stream and checks every result beat against a predictor.
// Depends on cgnt_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_canny_gradient_nms_threshold;

    import cgnt_pkg::*;

    localparam int LINE_MAX     = 2048;
    localparam int ROWS_MAX     = 2048;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 950;
    localparam int MAX_PRINTS   = 50;

    // Frame content patterns
    typedef enum int {
        PAT_NOISE,
        PAT_LEVELS,
        PAT_RAMP,
        PAT_SPIKE
    } pattern_t;

    // Threshold pairs
    typedef enum int {
        THR_ZERO,
        THR_TOP,
        THR_ALL_ONES,
        THR_SPREAD,
        THR_CROSSED,
        THR_LOW_BAND
    } thr_pick_t;

    // One row of the directed table
    typedef struct packed {
        bit                   is_cfg;
        cfg_idx_t             idx;
        logic [MAG_BITS-1:0]  data;
        logic                 drain;
        logic [7:0]           pix;
        bit                   none_typed;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [PIXEL_IN_BITS-1:0]      s_axis_tdata;   // [7:0] pixel
    logic [0:0]                    s_axis_tuser;   // [0] action (1 = drain)
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [OUT_DATA_BITS-1:0]      m_axis_tdata;   // [16:0] kept_mag_sq, rest zero
    logic [CLASS_BITS-1:0]         m_axis_tuser;   // [1:0] edge_class
    logic                          m_axis_tlast;   // frame_last
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;

    // Predictor state: line stores, position and registers
    logic [7:0]          px_rows  [0:4*LINE_MAX-1];
    logic [MAG_BITS-1:0] mag_rows [0:4*LINE_MAX-1];
    dir_t                dir_rows [0:4*LINE_MAX-1];
    int                  row_pos;
    int                  col_pos;
    logic [11:0]         width_reg;
    logic [11:0]         height_reg;
    logic [MAG_BITS-1:0] high_sq;
    logic [MAG_BITS-1:0] low_sq;

    result_t   pending_edges [$];
    plan_row_t plan [$];
    int        mismatches  = 0;
    int        beats_seen  = 0;
    int        cycle_count = 0;
    int        small_items = 0;
    int        holds_asked = 0;
    int        holds_done  = 0;
    bit        idle_on     = 1'b1;
    bit        need_size   = 1'b1;

    canny_gradient_nms_threshold #(
        .MAX_WIDTH  (LINE_MAX),
        .PIXEL_BITS (8)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_canny_gradient_nms_threshold: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_model();
        for (int i = 0; i < 4 * LINE_MAX; i++)
        begin
            px_rows[i]  = '0;
            mag_rows[i] = '0;
            dir_rows[i] = DIR_0;
        end
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = 12'd640;
        height_reg = 12'd480;
        high_sq    = '0;
        low_sq     = '0;
    endfunction

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 3)
            w = 3;
        if (w > LINE_MAX)
            w = LINE_MAX;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        if (h < 3)
            h = 3;
        if (h > ROWS_MAX)
            h = ROWS_MAX;
        return h;
    endfunction

    // Four rows rotate through the line stores
    function automatic int slot(input int r, input int c);
        return (r & 3) * LINE_MAX + c;
    endfunction

    // Pixels outside the frame read as zero
    function automatic int pix_at(input int r, input int c, input int w, input int h);
        if (r < 0 || r >= h || c < 0 || c >= w)
            return 0;
        return int'(px_rows[slot(r, c)]);
    endfunction

    // Central differences, squared magnitude and direction bin of one pixel
    function automatic void gradient_at(input int r, input int c, input int w, input int h);
        int     gx;
        int     gy;
        longint ax;
        longint ay;
        longint m2;
        longint s2;
        dir_t   bin;
        gx = pix_at(r, c + 1, w, h) - pix_at(r, c - 1, w, h);
        gy = pix_at(r + 1, c, w, h) - pix_at(r - 1, c, w, h);
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        m2 = ax * ax + ay * ay;
        s2 = (ax + ay) * (ax + ay);
        if (m2 > longint'(MAG_MAX))
            m2 = longint'(MAG_MAX);
        if (s2 < 2 * ax * ax)
            bin = DIR_0;
        else if (s2 < 2 * ay * ay)
            bin = DIR_90;
        else if ((gx > 0) == (gy > 0))
            bin = DIR_45;
        else
            bin = DIR_135;
        mag_rows[slot(r, c)] = m2[MAG_BITS-1:0];
        dir_rows[slot(r, c)] = bin;
    endfunction

    // Keep the magnitude only if it is a ridge along its bin and off the touched border
    function automatic logic [MAG_BITS-1:0] suppress_at(input int r, input int c,
                                                        input int w, input int h);
        logic [MAG_BITS-1:0] m;
        logic [MAG_BITS-1:0] a;
        logic [MAG_BITS-1:0] b;
        bit                  on_col;
        bit                  on_row;
        m      = mag_rows[slot(r, c)];
        on_col = (c == 0) || (c == w - 1);
        on_row = (r == 0) || (r == h - 1);
        if (m == '0)
            return '0;
        case (dir_rows[slot(r, c)])
            DIR_0:
            begin
                if (on_col)
                    return '0;
                a = mag_rows[slot(r, c - 1)];
                b = mag_rows[slot(r, c + 1)];
            end
            DIR_45:
            begin
                if (on_col || on_row)
                    return '0;
                a = mag_rows[slot(r - 1, c - 1)];
                b = mag_rows[slot(r + 1, c + 1)];
            end
            DIR_90:
            begin
                if (on_row)
                    return '0;
                a = mag_rows[slot(r - 1, c)];
                b = mag_rows[slot(r + 1, c)];
            end
            default:
            begin
                if (on_col || on_row)
                    return '0;
                a = mag_rows[slot(r - 1, c + 1)];
                b = mag_rows[slot(r + 1, c - 1)];
            end
        endcase
        if (m < a || m < b)
            return '0;
        return m;
    endfunction

    // Advance the predictor by one accepted beat; returns 1 when a result is due
    function automatic bit predict_step(input logic drain, input logic [7:0] pix,
                                        output result_t res);
        int                  w;
        int                  h;
        int                  row;
        int                  col;
        int                  qr;
        int                  qc;
        logic [MAG_BITS-1:0] kept;
        bit                  fin;
        bit                  got;
        w   = eff_width();
        h   = eff_height();
        row = row_pos;
        col = col_pos;
        fin = 1'b0;
        got = 1'b0;
        res = '0;
        if (drain && row == 0 && col == 0)
            return 1'b0;
        if (row < h)
            px_rows[slot(row, col)] = drain ? 8'd0 : pix;
        if (row >= 1 && row <= h)
            gradient_at(row - 1, col, w, h);
        if (col >= 1)
        begin
            qr = row - 2;
            qc = col - 1;
        end
        else
        begin
            qr = row - 3;
            qc = w - 1;
        end
        if (qr >= 0 && qr < h)
        begin
            kept     = suppress_at(qr, qc, w, h);
            res.mag  = kept;
            res.cls  = (kept > high_sq) ? CLS_STRONG : (kept > low_sq) ? CLS_WEAK : CLS_NONE;
            fin      = (qr == h - 1) && (qc == w - 1);
            res.last = fin;
            got      = 1'b1;
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
        end
        if (fin)
        begin
            col = 0;
            row = 0;
        end
        row_pos = row;
        col_pos = col;
        return got;
    endfunction

    function automatic void apply_register(input cfg_idx_t idx, input logic [MAG_BITS-1:0] val);
        case (idx)
            CFG_WIDTH:
            begin
                width_reg = val[11:0];
                row_pos   = 0;
                col_pos   = 0;
            end
            CFG_HEIGHT:
            begin
                height_reg = val[11:0];
                row_pos    = 0;
                col_pos    = 0;
            end
            CFG_HIGH: high_sq = val;
            default:  low_sq  = val;
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns result beat %0d: %s", $time, beats_seen, what);
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (pending_edges.size() == 0)
                flag_mismatch("result beat with no prediction waiting");
            else
            begin
                want = pending_edges.pop_front();
                if (m_axis_tdata[MAG_BITS-1:0] !== want.mag)
                    flag_mismatch($sformatf("kept_mag_sq %0d, predicted %0d",
                                            m_axis_tdata[MAG_BITS-1:0], want.mag));
                if (m_axis_tuser !== want.cls)
                    flag_mismatch($sformatf("edge_class %0d, predicted %0d",
                                            m_axis_tuser, want.cls));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("frame_last %0b, predicted %0b",
                                            m_axis_tlast, want.last));
            end
        end
    end

    // Result sink: random stall before each beat, plus long hold-offs on request
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one beat after a random gap; predict once it is taken
    task automatic push_item(input logic drain, input logic [7:0] pix, input bit none_typed);
        int      gap;
        bit      has;
        result_t res;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= drain;
        do
            @(posedge clk);
        while (!s_axis_tready);
        has = predict_step(drain, pix, res);
        if (has && !none_typed)
            pending_edges.push_back(res);
        @(negedge clk);
    endtask

    // Hold the input until every predicted result has come, then let the pipe empty
    task automatic settle_results();
        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [MAG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void add_item(input logic drain, input logic [7:0] pix,
                                     input bit none_typed);
        plan_row_t row;
        row            = '0;
        row.drain      = drain;
        row.pix        = pix;
        row.none_typed = none_typed;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input cfg_idx_t idx, input logic [MAG_BITS-1:0] val);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = val;
        plan.push_back(row);
    endfunction

    // One random frame: size and thresholds, then pixels and the drain tail
    task automatic run_frame(input int fr);
        int                  w;
        int                  h;
        int                  total;
        int                  base;
        int                  sx;
        int                  sy;
        int                  pause_at;
        int                  hold_at;
        int                  lvl;
        bit                  big;
        bit                  cut;
        bit                  early;
        bit                  late;
        logic                drain;
        logic [7:0]          pix;
        logic [MAG_BITS-1:0] val;
        logic [MAG_BITS-1:0] lo;
        logic [MAG_BITS-1:0] hi;
        pattern_t            pat;
        thr_pick_t           pick;

        big = (fr == 3) || (fr == 8);
        settle_results();
        idle_on = ($urandom_range(0, 3) != 0);

        // Frame size; out-of-range values and junk above bit 11 included
        if (big || need_size || $urandom_range(0, 2) != 0)
        begin
            if (fr == 3)
            begin
                write_reg(CFG_WIDTH, 17'h00FFF);
                write_reg(CFG_HEIGHT, 17'd3);
            end
            else if (fr == 8)
            begin
                write_reg(CFG_HEIGHT, 17'd2048);
                write_reg(CFG_WIDTH, 17'd3);
            end
            else
            begin
                val = ($urandom_range(0, 31) << 12) | $urandom_range(0, 16);
                write_reg(CFG_WIDTH, val);
                val = ($urandom_range(0, 31) << 12) | $urandom_range(0, 10);
                write_reg(CFG_HEIGHT, val);
            end
            need_size = big;
        end

        // Threshold pair
        if ($urandom_range(0, 2) != 0)
        begin
            pick = thr_pick_t'($urandom_range(0, 5));
            case (pick)
                THR_ZERO:
                begin
                    hi = '0;
                    lo = '0;
                end
                THR_TOP:
                begin
                    hi = 17'd130050;
                    lo = '0;
                end
                THR_ALL_ONES:
                begin
                    hi = '1;
                    lo = '1;
                end
                THR_SPREAD:
                begin
                    lo = $urandom_range(0, 40000);
                    hi = lo + $urandom_range(0, 60000);
                end
                THR_CROSSED:
                begin
                    hi = $urandom_range(0, 40000);
                    lo = hi + $urandom_range(0, 60000);
                end
                default:
                begin
                    lo = $urandom_range(0, 3000);
                    hi = lo + $urandom_range(0, 20000);
                end
            endcase
            write_reg(CFG_HIGH, hi);
            write_reg(CFG_LOW, lo);
        end

        w     = eff_width();
        h     = eff_height();
        total = w * h + 2 * w + 1;
        cut   = !big && ($urandom_range(0, 9) == 0);
        if (cut)
        begin
            total     = $urandom_range(1, total - 1);
            need_size = 1'b1;
        end
        early    = ($urandom_range(0, 5) == 0);
        late     = ($urandom_range(0, 5) == 0);
        pat      = pattern_t'($urandom_range(0, 3));
        base     = $urandom_range(0, 255);
        sx       = $urandom_range(0, 40);
        sy       = $urandom_range(0, 40);
        pause_at = (fr == 1 || $urandom_range(0, 5) == 0) ? $urandom_range(0, total - 1) : -1;
        hold_at  = (fr == 2 || $urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;

        // A drain while nothing is started is dropped by the block
        if (row_pos == 0 && col_pos == 0 && $urandom_range(0, 7) == 0)
            push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);

        for (int k = 0; k < total; k++)
        begin
            if (k == pause_at)
                settle_results();
            if (k == hold_at)
                holds_asked++;
            case (pat)
                PAT_NOISE:  pix = $urandom_range(0, 255);
                PAT_LEVELS:
                begin
                    lvl = $urandom_range(0, 2);
                    pix = (lvl == 0) ? 8'h00 : (lvl == 1) ? 8'h80 : 8'hFF;
                end
                PAT_RAMP:   pix = (base + (k % w) * sx + (k / w) * sy) & 255;
                default:    pix = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : base;
            endcase
            // Early drains stand in for zero pixels; late pixels act as drains
            if (k < w * h)
                drain = early && (k != 0) && ($urandom_range(0, 9) == 0);
            else
                drain = !(late && ($urandom_range(0, 2) == 0));
            push_item(drain, pix, 1'b0);
            if (!big)
                small_items++;
        end
    endtask

    initial
    begin : stimulus
        int fr;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_data      = '0;
        clear_model();

        // Directed table: default frame size first, then one 3x3 frame
        add_item(1'b1, 8'h00, 1'b1);        // drain with nothing started
        add_item(1'b0, 8'hFF, 1'b1);        // opens a 640x480 frame
        add_cfg(CFG_WIDTH, 17'h1F003);      // abort; bits above 11 dropped
        add_cfg(CFG_HEIGHT, 17'h00002);     // clamps up to 3
        add_cfg(CFG_HIGH, 17'd130050);
        add_cfg(CFG_LOW, 17'd0);
        add_item(1'b0, 8'h00, 1'b1);
        add_item(1'b1, 8'h00, 1'b1);        // drain in place of a pixel
        add_item(1'b0, 8'hFF, 1'b1);
        add_item(1'b0, 8'h00, 1'b1);
        add_item(1'b0, 8'h80, 1'b1);        // full-scale diagonal, equal to high
        add_item(1'b0, 8'hFF, 1'b1);
        add_item(1'b0, 8'hFF, 1'b1);
        add_item(1'b0, 8'hFF, 1'b0);
        add_item(1'b0, 8'hFF, 1'b0);        // ties its diagonal neighbour
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b0, 8'h5A, 1'b0);        // pixel after the frame acts as drain
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'h00, 1'b0);        // frame_last

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle_results();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                push_item(plan[i].drain, plan[i].pix, plan[i].none_typed);
        end

        // Random frames, with one very wide and one very tall frame among them
        fr = 0;
        while (small_items < RANDOM_ITEMS || fr < 10)
        begin
            run_frame(fr);
            fr++;
        end

        settle_results();
        if (mismatches == 0)
            $display("tb_canny_gradient_nms_threshold: PASS");
        else
            $display("tb_canny_gradient_nms_threshold: FAIL");
        $finish;
    end

endmodule

### canny_gradient_nms_threshold.f
src/cgnt_pkg.sv
src/cgnt_ram.sv
src/canny_gradient_nms_threshold.sv
tb/tb_canny_gradient_nms_threshold.sv
